// ===== sv/jsu_pkg.sv =====
// Shared types, codes and UTF-8 helpers for the JSON string unescaper.
package jsu_pkg;

  // Input operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_DATA  = 2'd1;
  localparam logic [1:0] OP_EOL   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_BYTE   = 3'd0;
  localparam logic [2:0] ST_DONE   = 3'd1;
  localparam logic [2:0] ST_NOQUO  = 3'd2;
  localparam logic [2:0] ST_BADESC = 3'd3;
  localparam logic [2:0] ST_BADHEX = 3'd4;
  localparam logic [2:0] ST_BADSUR = 3'd5;
  localparam logic [2:0] ST_UNTERM = 3'd6;

  // Command queue geometry
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } out_t;

  // One decoded command: a raw byte, a code point to encode, or a status
  typedef struct packed {
    logic        raw;
    logic [2:0]  status;
    logic [20:0] cp;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Index of the last UTF-8 byte for a code point (length minus one)
  function automatic logic [1:0] utf8_last(input logic [20:0] cp);
    logic [1:0] r;
    if (cp <= 21'h00007F) r = 2'd0;
    else if (cp <= 21'h0007FF) r = 2'd1;
    else if (cp <= 21'h00FFFF) r = 2'd2;
    else r = 2'd3;
    return r;
  endfunction

  // Byte number idx of the UTF-8 encoding of cp
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                           input logic [1:0]  last,
                                           input logic [1:0]  idx);
    logic [1:0] from_end;
    logic [7:0] r;
    from_end = last - idx;
    if (idx == 2'd0) begin
      case (last)
        2'd0: r = {1'b0, cp[6:0]};
        2'd1: r = {3'b110, cp[10:6]};
        2'd2: r = {4'b1110, cp[15:12]};
        default: r = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (from_end)
        2'd0: r = {2'b10, cp[5:0]};
        2'd1: r = {2'b10, cp[11:6]};
        default: r = {2'b10, cp[17:12]};
      endcase
    end
    return r;
  endfunction

endpackage

// ===== sv/jsu_front.sv =====
// Front end: accepts input beats, runs the string parser, pushes commands.
module jsu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  jsu_pkg::in_t      in_beat,
  input  jsu_pkg::q_stat_t  q_stat,
  output logic              push,
  output jsu_pkg::cmd_t     push_cmd
);

  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_BLANK  = 4'd1;
  localparam logic [3:0] PH_BODY   = 4'd2;
  localparam logic [3:0] PH_ESC    = 4'd3;
  localparam logic [3:0] PH_HEX1   = 4'd4;
  localparam logic [3:0] PH_PAIRBS = 4'd5;
  localparam logic [3:0] PH_PAIRU  = 4'd6;
  localparam logic [3:0] PH_HEX2   = 4'd7;
  localparam logic [3:0] PH_OVER   = 4'd8;

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  hi_r, hi_nxt;

  logic [7:0]  c;
  logic [3:0]  hex_val;
  logic        hex_ok;
  logic [15:0] unit;
  logic        fail_en;
  logic [2:0]  fail_code;
  logic        accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign c        = in_beat.data_byte;
  assign unit     = {acc_r[11:0], hex_val};

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) hex_val = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) hex_val = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) hex_val = 4'(c - 8'h37);
    else hex_ok = 1'b0;
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    hi_nxt    = hi_r;
    push      = 1'b0;
    push_cmd  = '0;
    fail_en   = 1'b0;
    fail_code = jsu_pkg::ST_BYTE;
    if (accept) begin
      if (in_beat.op == jsu_pkg::OP_START) begin
        phase_nxt = PH_BLANK;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        hi_nxt    = '0;
      end else if ((in_beat.op == jsu_pkg::OP_DATA || in_beat.op == jsu_pkg::OP_EOL)
                   && phase_r != PH_IDLE && phase_r != PH_OVER) begin
        if (in_beat.op == jsu_pkg::OP_EOL) begin
          fail_en   = 1'b1;
          fail_code = (phase_r == PH_BLANK) ? jsu_pkg::ST_NOQUO : jsu_pkg::ST_UNTERM;
        end else begin
          case (phase_r)
            PH_BLANK: begin
              if (c == 8'h22) begin
                phase_nxt = PH_BODY;
              end else if (c != 8'h20 && c != 8'h09 && c != 8'h0D && c != 8'h0A) begin
                fail_en   = 1'b1;
                fail_code = jsu_pkg::ST_NOQUO;
              end
            end
            PH_BODY: begin
              if (c == 8'h22) begin
                phase_nxt       = PH_OVER;
                push            = 1'b1;
                push_cmd.status = jsu_pkg::ST_DONE;
              end else if (c == 8'h5C) begin
                phase_nxt = PH_ESC;
              end else begin
                push        = 1'b1;
                push_cmd.raw = 1'b1;
                push_cmd.cp = {13'd0, c};
              end
            end
            PH_ESC: begin
              phase_nxt    = PH_BODY;
              push         = 1'b1;
              push_cmd.raw = 1'b1;
              case (c)
                8'h22, 8'h5C, 8'h2F: push_cmd.cp = {13'd0, c};
                8'h62: push_cmd.cp = 21'h08;
                8'h66: push_cmd.cp = 21'h0C;
                8'h6E: push_cmd.cp = 21'h0A;
                8'h72: push_cmd.cp = 21'h0D;
                8'h74: push_cmd.cp = 21'h09;
                8'h75: begin
                  push      = 1'b0;
                  phase_nxt = PH_HEX1;
                  acc_nxt   = '0;
                  cnt_nxt   = '0;
                end
                default: begin
                  push      = 1'b0;
                  fail_en   = 1'b1;
                  fail_code = jsu_pkg::ST_BADESC;
                end
              endcase
            end
            PH_PAIRBS: begin
              if (c == 8'h5C) begin
                phase_nxt = PH_PAIRU;
              end else begin
                fail_en   = 1'b1;
                fail_code = jsu_pkg::ST_BADSUR;
              end
            end
            PH_PAIRU: begin
              if (c == 8'h75) begin
                phase_nxt = PH_HEX2;
                acc_nxt   = '0;
                cnt_nxt   = '0;
              end else begin
                fail_en   = 1'b1;
                fail_code = jsu_pkg::ST_BADSUR;
              end
            end
            PH_HEX1, PH_HEX2: begin
              if (!hex_ok) begin
                fail_en   = 1'b1;
                fail_code = jsu_pkg::ST_BADHEX;
              end else if (cnt_r != 2'd3) begin
                acc_nxt = unit;
                cnt_nxt = cnt_r + 2'd1;
              end else begin
                acc_nxt = '0;
                cnt_nxt = '0;
                if (phase_r == PH_HEX1) begin
                  if (unit >= 16'hD800 && unit <= 16'hDBFF) begin
                    hi_nxt    = unit[9:0];
                    phase_nxt = PH_PAIRBS;
                  end else if (unit >= 16'hDC00 && unit <= 16'hDFFF) begin
                    fail_en   = 1'b1;
                    fail_code = jsu_pkg::ST_BADSUR;
                  end else begin
                    phase_nxt   = PH_BODY;
                    push        = 1'b1;
                    push_cmd.cp = {5'd0, unit};
                  end
                end else if (unit < 16'hDC00 || unit > 16'hDFFF) begin
                  fail_en   = 1'b1;
                  fail_code = jsu_pkg::ST_BADSUR;
                end else begin
                  // supplementary plane: 0x10000 + (high bits : low bits)
                  phase_nxt   = PH_BODY;
                  hi_nxt      = '0;
                  push        = 1'b1;
                  push_cmd.cp = 21'h10000 + {1'b0, hi_r, unit[9:0]};
                end
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
        if (fail_en) begin
          phase_nxt       = PH_OVER;
          push            = 1'b1;
          push_cmd        = '0;
          push_cmd.status = fail_code;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      cnt_r   <= '0;
      hi_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      hi_r    <= hi_nxt;
    end
  end

endmodule

// ===== sv/jsu_queue.sv =====
// Small command FIFO between the parser and the UTF-8 expander.
module jsu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  jsu_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output jsu_pkg::cmd_t     head,
  output jsu_pkg::q_stat_t  q_stat
);

  jsu_pkg::cmd_t mem_r [jsu_pkg::Q_DEPTH];
  logic [jsu_pkg::Q_AW-1:0] wptr_r, wptr_nxt;
  logic [jsu_pkg::Q_AW-1:0] rptr_r, rptr_nxt;
  logic [jsu_pkg::Q_CW-1:0] cnt_r, cnt_nxt;

  assign head         = mem_r[rptr_r];
  assign q_stat.full  = (cnt_r == jsu_pkg::Q_CW'(jsu_pkg::Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("command pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= jsu_pkg::Q_CW'(jsu_pkg::Q_DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== sv/jsu_back.sv =====
// Back end: expands queued commands into output beats, one byte per cycle while out_ready allows.
module jsu_back (
  input  logic              clk,
  input  logic              rst_n,
  input  jsu_pkg::cmd_t     head,
  input  jsu_pkg::q_stat_t  q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output jsu_pkg::out_t     out_beat
);

  logic [1:0]    idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  jsu_pkg::out_t out_r, out_nxt;
  logic [1:0]    last_idx;
  logic          single;
  logic          fire;

  assign single   = head.raw || (head.status != jsu_pkg::ST_BYTE);
  assign last_idx = single ? 2'd0 : jsu_pkg::utf8_last(head.cp);
  assign fire     = !q_stat.empty && (!out_valid_r || out_ready);
  assign pop      = fire && (idx_r == last_idx);

  always_comb begin
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt   = 1'b1;
      out_nxt.status  = head.status;
      out_nxt.last    = (idx_r == last_idx);
      if (head.status != jsu_pkg::ST_BYTE) out_nxt.out_byte = 8'h00;
      else if (head.raw) out_nxt.out_byte = head.cp[7:0];
      else out_nxt.out_byte = jsu_pkg::utf8_byte(head.cp, last_idx, idx_r);
      idx_nxt = (idx_r == last_idx) ? 2'd0 : idx_r + 2'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

  a_status_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status != jsu_pkg::ST_BYTE |-> out_r.last && out_r.out_byte == 8'h00)
    else $error("status beat not final or carries data");

  a_mid_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd0 |-> !q_stat.empty)
    else $error("expander mid-sequence with empty queue");

  a_cont_byte: assert property (@(posedge clk) disable iff (!rst_n)
    fire && idx_r != 2'd0 |=> out_r.out_byte[7:6] == 2'b10)
    else $error("later UTF-8 byte is not a continuation byte");

endmodule

// ===== sv/json_string_unescape.sv =====
// Top level of the JSON string unescaper: parser, command queue, UTF-8 expander.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid / in_ready  | in_beat  (op, data_byte)
//  out     | output    | out_valid / out_ready| out_beat (out_byte, status, last)
//
//  One input beat is taken per cycle while the command queue has room; the
//  parser decides it in that same cycle and queues at most one command.
//  Each command drains as 1 to 4 output beats, one per cycle while out_ready
//  allows, through the single output register.
//  The 4-entry queue lets the parser run ahead of a stalled or busy back end;
//  in_ready drops only when the queue is full.
//  Reset: rst_n synchronous, active low; parser idle until a start op.
module json_string_unescape (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  jsu_pkg::in_t  in_beat,
  output logic          out_valid,
  input  logic          out_ready,
  output jsu_pkg::out_t out_beat
);

  jsu_pkg::q_stat_t q_stat;
  jsu_pkg::cmd_t    push_cmd;
  jsu_pkg::cmd_t    head;
  logic             push;
  logic             pop;

  // Parser: blank skip, quote, escapes, hex units, surrogate pairing
  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_beat  (in_beat),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouples the 1-in rate from the up-to-4-out bursts
  jsu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // UTF-8 encoder and output register
  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

endmodule

// ===== tb/sv/jsu_decode_checker.sv =====
// Channel monitor for the JSON string unescaper: predicts decoded beats and compares them.
`timescale 1ns / 100ps

module jsu_decode_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  jsu_pkg::in_t  in_beat,
  input  logic          out_valid,
  input  logic          out_ready,
  input  jsu_pkg::out_t out_beat,
  output int            fail_count,
  output int            pending,
  output int            n_results,
  output int            n_done,
  output int            n_fault
);

  localparam int SHOW_MAX = 10;

  localparam logic [15:0] SUR_HI_MIN = 16'hD800;
  localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_BLANK, SCAN_BODY, SCAN_ESC, SCAN_HEX1,
    SCAN_PAIR_BS, SCAN_PAIR_U, SCAN_HEX2, SCAN_OVER
  } scan_e;

  scan_e       scan    = SCAN_IDLE;
  logic [15:0] hex_acc = '0;
  logic [1:0]  hex_cnt = '0;
  logic [9:0]  hi_bits = '0;

  jsu_pkg::out_t decoded_q[$];
  int   bad_total   = 0;
  int   got_total   = 0;
  int   done_total  = 0;
  int   fault_total = 0;

  function automatic int nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic enqueue(input jsu_pkg::out_t x);
    decoded_q.insert(decoded_q.size(), x);
  endtask

  task automatic push_one(input logic [7:0] b, input logic [2:0] st);
    enqueue('{b, st, 1'b1});
  endtask

  // any status other than a byte closes the string
  task automatic push_fail(input logic [2:0] st);
    scan = SCAN_OVER;
    push_one(8'h00, st);
  endtask

  task automatic push_code(input logic [20:0] cp);
    logic [7:0] seq [0:3];
    int n;
    if (cp <= 21'h7F) begin
      seq[0] = cp[7:0];
      n = 1;
    end else if (cp <= 21'h7FF) begin
      seq[0] = 8'hC0 | {3'b000, cp[10:6]};
      seq[1] = 8'h80 | {2'b00, cp[5:0]};
      n = 2;
    end else if (cp <= 21'hFFFF) begin
      seq[0] = 8'hE0 | {4'h0, cp[15:12]};
      seq[1] = 8'h80 | {2'b00, cp[11:6]};
      seq[2] = 8'h80 | {2'b00, cp[5:0]};
      n = 3;
    end else begin
      seq[0] = 8'hF0 | {5'b00000, cp[20:18]};
      seq[1] = 8'h80 | {2'b00, cp[17:12]};
      seq[2] = 8'h80 | {2'b00, cp[11:6]};
      seq[3] = 8'h80 | {2'b00, cp[5:0]};
      n = 4;
    end
    for (int i = 0; i < n; i++)
      enqueue('{seq[i], jsu_pkg::ST_BYTE, i == n - 1});
  endtask

  task automatic decode_beat(input jsu_pkg::in_t b);
    logic [7:0]  c;
    logic [15:0] unit;
    int          d;
    c = b.data_byte;
    if (b.op == jsu_pkg::OP_START) begin
      scan    = SCAN_BLANK;
      hex_acc = '0;
      hex_cnt = '0;
      hi_bits = '0;
    end else if ((b.op == jsu_pkg::OP_DATA || b.op == jsu_pkg::OP_EOL) &&
                 scan != SCAN_IDLE && scan != SCAN_OVER) begin
      if (b.op == jsu_pkg::OP_EOL) begin
        push_fail(scan == SCAN_BLANK ? jsu_pkg::ST_NOQUO : jsu_pkg::ST_UNTERM);
      end else begin
        case (scan)
          SCAN_BLANK: begin
            if (c == "\"") scan = SCAN_BODY;
            else if (c != " " && c != 8'h09 && c != 8'h0D && c != 8'h0A)
              push_fail(jsu_pkg::ST_NOQUO);
          end
          SCAN_BODY: begin
            if (c == "\"") begin
              scan = SCAN_OVER;
              push_one(8'h00, jsu_pkg::ST_DONE);
            end else if (c == "\\") begin
              scan = SCAN_ESC;
            end else begin
              push_one(c, jsu_pkg::ST_BYTE);
            end
          end
          SCAN_ESC: begin
            scan = SCAN_BODY;
            case (c)
              "\"", "\\", "/": push_one(c, jsu_pkg::ST_BYTE);
              "b": push_one(8'h08, jsu_pkg::ST_BYTE);
              "f": push_one(8'h0C, jsu_pkg::ST_BYTE);
              "n": push_one(8'h0A, jsu_pkg::ST_BYTE);
              "r": push_one(8'h0D, jsu_pkg::ST_BYTE);
              "t": push_one(8'h09, jsu_pkg::ST_BYTE);
              "u": begin
                scan    = SCAN_HEX1;
                hex_acc = '0;
                hex_cnt = '0;
              end
              default: push_fail(jsu_pkg::ST_BADESC);
            endcase
          end
          SCAN_PAIR_BS: begin
            if (c != "\\") push_fail(jsu_pkg::ST_BADSUR);
            else scan = SCAN_PAIR_U;
          end
          SCAN_PAIR_U: begin
            if (c != "u") begin
              push_fail(jsu_pkg::ST_BADSUR);
            end else begin
              scan    = SCAN_HEX2;
              hex_acc = '0;
              hex_cnt = '0;
            end
          end
          SCAN_HEX1, SCAN_HEX2: begin
            d = nibble_of(c);
            if (d < 0) begin
              push_fail(jsu_pkg::ST_BADHEX);
            end else begin
              hex_acc = {hex_acc[11:0], d[3:0]};
              if (hex_cnt < 2'd3) begin
                hex_cnt = hex_cnt + 2'd1;
              end else begin
                hex_cnt = '0;
                unit    = hex_acc;
                hex_acc = '0;
                if (scan == SCAN_HEX1) begin
                  if (unit >= SUR_HI_MIN && unit <= SUR_HI_MAX) begin
                    hi_bits = unit[9:0];
                    scan    = SCAN_PAIR_BS;
                  end else if (unit >= SUR_LO_MIN && unit <= SUR_LO_MAX) begin
                    push_fail(jsu_pkg::ST_BADSUR);
                  end else begin
                    scan = SCAN_BODY;
                    push_code({5'd0, unit});
                  end
                end else if (unit < SUR_LO_MIN || unit > SUR_LO_MAX) begin
                  push_fail(jsu_pkg::ST_BADSUR);
                end else begin
                  scan = SCAN_BODY;
                  push_code(21'h10000 + {1'b0, hi_bits, unit[9:0]});
                  hi_bits = '0;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  endtask

  task automatic check_result(input jsu_pkg::out_t got);
    jsu_pkg::out_t want;
    got_total++;
    if (got.status == jsu_pkg::ST_DONE) done_total++;
    else if (got.status != jsu_pkg::ST_BYTE) fault_total++;
    if (decoded_q.size() == 0) begin
      bad_total++;
      if (bad_total <= SHOW_MAX)
        $display("%0t: unexpected out beat byte=%h status=%0d last=%b",
                 $realtime, got.out_byte, got.status, got.last);
    end else begin
      want = decoded_q.pop_front();
      if (got.out_byte !== want.out_byte || got.status !== want.status ||
          got.last !== want.last) begin
        bad_total++;
        if (bad_total <= SHOW_MAX)
          $display({"%0t: out beat mismatch: want byte=%h status=%0d last=%b, ",
                    "got byte=%h status=%0d last=%b"},
                   $realtime, want.out_byte, want.status, want.last,
                   got.out_byte, got.status, got.last);
      end
    end
  endtask

  // input first: a beat taken at this edge cannot show up on the output yet
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) decode_beat(in_beat);
      if (out_valid && out_ready) check_result(out_beat);
    end
    fail_count <= bad_total;
    pending    <= decoded_q.size();
    n_results  <= got_total;
    n_done     <= done_total;
    n_fault    <= fault_total;
  end

endmodule

// ===== tb/sv/json_string_unescape_tb.sv =====
// Testbench top for the JSON string unescaper: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module json_string_unescape_tb;

  // op value the block must ignore
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam int ITEMS       = 310;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 24;

  // UTF-16 surrogate ranges, for building pairs and broken pairs
  localparam logic [15:0] SUR_HI_MIN = 16'hD800;
  localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  jsu_pkg::in_t  in_beat   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  jsu_pkg::out_t out_beat;

  int fail_count;
  int pending;
  int n_results;
  int n_done;
  int n_fault;

  int cycles      = 0;
  int stall_left  = 0;
  int n_live      = 0;   // beats sent while a string is being built
  int n_str       = 0;
  bit quiet       = 1'b0; // no idling on either side while set
  bit string_open = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  json_string_unescape i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat)
  );

  jsu_decode_checker i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (out_beat),
    .fail_count (fail_count),
    .pending    (pending),
    .n_results  (n_results),
    .n_done     (n_done),
    .n_fault    (n_fault)
  );

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Hex digit with random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return "0" + {4'h0, nib};
    return ($urandom_range(0, 1) ? "A" : "a") + {4'h0, nib} - 8'd10;
  endfunction

  // Run watchdog: the slowest legal run is far below this.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[json_string_unescape] ERROR");
      $finish;
    end
  end

  // Receiver side: random back-pressure stretches, none while quiet.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      out_ready <= 1'b1;
    end
  end

  // One input beat: optional idle gap, then hold valid until taken.
  // Valid is only lowered when a gap follows, so it never drops and
  // rises in the same step.
  task automatic send_beat(input logic [1:0] op, input logic [7:0] b);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{op: op, data_byte: b};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (string_open) n_live++;
  endtask

  task automatic send_unit(input logic [15:0] u);
    send_beat(jsu_pkg::OP_DATA, "\\");
    send_beat(jsu_pkg::OP_DATA, "u");
    for (int i = 3; i >= 0; i--) send_beat(jsu_pkg::OP_DATA, hex_char(u[i*4 +: 4]));
  endtask

  // Short directed pass: ignored beats while idle, blanks, raw extremes,
  // a simple escape, a surrogate pair to a 4-byte code point, bytes after
  // done, and end of line before the opening quote.
  task automatic run_directed();
    send_beat(jsu_pkg::OP_DATA, "A");
    send_beat(jsu_pkg::OP_EOL, 8'hFF);
    send_beat(OP_NONE, 8'h00);
    send_beat(jsu_pkg::OP_START, 8'h00);
    send_beat(jsu_pkg::OP_DATA, " ");
    send_beat(jsu_pkg::OP_DATA, "\"");
    send_beat(jsu_pkg::OP_DATA, 8'h00);
    send_beat(jsu_pkg::OP_DATA, 8'hFF);
    send_beat(jsu_pkg::OP_DATA, "\\");
    send_beat(jsu_pkg::OP_DATA, "n");
    send_unit(16'hD83D);
    send_unit(16'hDE00);
    send_beat(jsu_pkg::OP_DATA, "\"");
    send_beat(jsu_pkg::OP_DATA, "x");
    send_beat(jsu_pkg::OP_START, 8'hFF);
    send_beat(jsu_pkg::OP_EOL, 8'h00);
  endtask

  // One random string: mostly well formed with random content, some with
  // an injected fault, some left unterminated or abandoned by a new start.
  task automatic random_string();
    int          r;
    int          n_elem;
    int          k;
    bit          dead;
    logic [7:0]  c;
    logic [15:0] u;
    dead = 1'b0;
    // stray beat between strings; predicted like any other
    if ($urandom_range(0, 15) == 0)
      send_beat($urandom_range(0, 1) ? jsu_pkg::OP_DATA : jsu_pkg::OP_EOL,
                8'($urandom_range(0, 255)));
    string_open = 1'b1;
    send_beat(jsu_pkg::OP_START, 8'($urandom_range(0, 255)));
    k = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
    repeat (k) begin
      case ($urandom_range(0, 3))
        0: c = " ";
        1: c = 8'h09;
        2: c = 8'h0D;
        default: c = 8'h0A;
      endcase
      send_beat(jsu_pkg::OP_DATA, c);
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_beat(jsu_pkg::OP_EOL, 8'($urandom_range(0, 255)));
      dead = 1'b1;
    end else if (r < 8) begin
      do c = 8'($urandom_range(0, 255));
      while (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A || c == "\"");
      send_beat(jsu_pkg::OP_DATA, c);
      dead = 1'b1;
    end else begin
      send_beat(jsu_pkg::OP_DATA, "\"");
    end
    n_elem = $urandom_range(0, 8);
    for (int e = 0; e < n_elem && !dead; e++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        do c = 8'($urandom_range(0, 255)); while (c == "\"" || c == "\\");
        send_beat(jsu_pkg::OP_DATA, c);
      end else if (r < 55) begin
        case ($urandom_range(0, 7))
          0: c = "\"";
          1: c = "\\";
          2: c = "/";
          3: c = "b";
          4: c = "f";
          5: c = "n";
          6: c = "r";
          default: c = "t";
        endcase
        send_beat(jsu_pkg::OP_DATA, "\\");
        send_beat(jsu_pkg::OP_DATA, c);
      end else if (r < 70) begin
        // BMP code point: 1, 2 or 3 UTF-8 bytes, boundaries now and then
        case ($urandom_range(0, 3))
          0: u = 16'($urandom_range(0, 16'h7F));
          1: u = 16'($urandom_range(16'h80, 16'h7FF));
          2: do u = 16'($urandom_range(16'h800, 16'hFFFF));
             while (u >= SUR_HI_MIN && u <= SUR_LO_MAX);
          default: begin
            case ($urandom_range(0, 7))
              0: u = 16'h0000;
              1: u = 16'h007F;
              2: u = 16'h0080;
              3: u = 16'h07FF;
              4: u = 16'h0800;
              5: u = 16'hD7FF;
              6: u = 16'hE000;
              default: u = 16'hFFFF;
            endcase
          end
        endcase
        send_unit(u);
      end else if (r < 80) begin
        // valid pair, range corners included
        case ($urandom_range(0, 5))
          0: begin
            send_unit(SUR_HI_MIN);
            send_unit(SUR_LO_MIN);
          end
          1: begin
            send_unit(SUR_HI_MAX);
            send_unit(SUR_LO_MAX);
          end
          default: begin
            send_unit(16'($urandom_range(SUR_HI_MIN, SUR_HI_MAX)));
            send_unit(16'($urandom_range(SUR_LO_MIN, SUR_LO_MAX)));
          end
        endcase
      end else if (r < 83) begin
        send_beat(OP_NONE, 8'($urandom_range(0, 255)));
      end else begin
        dead = 1'b1;
        case ($urandom_range(0, 7))
          0: begin // unknown escape letter
            do c = 8'($urandom_range(0, 255));
            while (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                   c == "n" || c == "r" || c == "t" || c == "u");
            send_beat(jsu_pkg::OP_DATA, "\\");
            send_beat(jsu_pkg::OP_DATA, c);
          end
          1: begin // non-hex digit, in the first or the second unit
            if ($urandom_range(0, 2) == 0)
              send_unit(16'($urandom_range(SUR_HI_MIN, SUR_HI_MAX)));
            send_beat(jsu_pkg::OP_DATA, "\\");
            send_beat(jsu_pkg::OP_DATA, "u");
            k = $urandom_range(0, 3);
            repeat (k) send_beat(jsu_pkg::OP_DATA, hex_char(4'($urandom_range(0, 15))));
            do c = 8'($urandom_range(0, 255));
            while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
            send_beat(jsu_pkg::OP_DATA, c);
          end
          2: send_unit(16'($urandom_range(SUR_LO_MIN, SUR_LO_MAX))); // lone low
          3: begin // high surrogate, then no backslash
            send_unit(16'($urandom_range(SUR_HI_MIN, SUR_HI_MAX)));
            do c = 8'($urandom_range(0, 255)); while (c == "\\");
            send_beat(jsu_pkg::OP_DATA, c);
          end
          4: begin // high surrogate, backslash, then not u
            send_unit(16'($urandom_range(SUR_HI_MIN, SUR_HI_MAX)));
            send_beat(jsu_pkg::OP_DATA, "\\");
            do c = 8'($urandom_range(0, 255)); while (c == "u");
            send_beat(jsu_pkg::OP_DATA, c);
          end
          5: begin // second unit outside the low range
            send_unit(16'($urandom_range(SUR_HI_MIN, SUR_HI_MAX)));
            do u = 16'($urandom_range(0, 16'hFFFF));
            while (u >= SUR_LO_MIN && u <= SUR_LO_MAX);
            send_unit(u);
          end
          6: begin // end of line inside an escape or its digits
            send_beat(jsu_pkg::OP_DATA, "\\");
            if ($urandom_range(0, 1)) begin
              send_beat(jsu_pkg::OP_DATA, "u");
              k = $urandom_range(0, 3);
              repeat (k) send_beat(jsu_pkg::OP_DATA, hex_char(4'($urandom_range(0, 15))));
            end
            send_beat(jsu_pkg::OP_EOL, 8'($urandom_range(0, 255)));
          end
          default: begin // end of line while a pair is open
            send_unit(16'($urandom_range(SUR_HI_MIN, SUR_HI_MAX)));
            k = $urandom_range(0, 2);
            if (k > 0) send_beat(jsu_pkg::OP_DATA, "\\");
            if (k > 1) send_beat(jsu_pkg::OP_DATA, "u");
            send_beat(jsu_pkg::OP_EOL, 8'($urandom_range(0, 255)));
          end
        endcase
      end
    end
    if (!dead) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        send_beat(jsu_pkg::OP_DATA, "\"");
        dead = 1'b1;
      end else if (r < 93) begin
        send_beat(jsu_pkg::OP_EOL, 8'($urandom_range(0, 255)));
        dead = 1'b1;
      end
      // otherwise left open; the next start abandons it
    end
    string_open = 1'b0;
    // trailing beat after the end; must be ignored
    if (dead && $urandom_range(0, 4) == 0)
      send_beat($urandom_range(0, 1) ? jsu_pkg::OP_DATA : jsu_pkg::OP_EOL,
                8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    while (n_live < ITEMS) begin
      // the first three strings of every twelve run without any idling
      quiet <= (n_str % 12) < 3;
      random_string();
      n_str++;
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("covered %0d random strings (%0d beats) after the directed pass",
             n_str, n_live);
    $display("checked %0d out beats: %0d strings closed, %0d error endings",
             n_results, n_done, n_fault);
    if (fail_count == 0 && pending == 0) begin
      $display("[json_string_unescape] OK");
    end else begin
      $display("[json_string_unescape] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/jsu_pkg.sv
sv/jsu_front.sv
sv/jsu_queue.sv
sv/jsu_back.sv
sv/json_string_unescape.sv
tb/sv/jsu_decode_checker.sv
tb/sv/json_string_unescape_tb.sv
